/* hw/rtl/rc4_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 package
// Shared constants, command and status bundles for the RC4 cipher core.
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int BYTE_W            = 8;
    localparam int SBOX_DEPTH        = 256;
    localparam int KEY_LEN_W         = 9;
    localparam int DEF_MAX_KEY_BYTES = 256;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd1;

    // item kinds
    localparam logic ACT_KEY  = 1'b0;
    localparam logic ACT_DATA = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic key_wr;    // write key byte from the input ports
        logic latch;     // capture the data byte
        logic ks_start;  // clear counters and indices ahead of a schedule
        logic init_wr;   // identity fill of the S-box
        logic ks_rd;     // schedule: read S[n] and key byte
        logic ks_sw;     // schedule: form j, read S[j]
        logic ks_wa;     // schedule: write S[n]
        logic ks_wb;     // schedule: write S[j], advance n and key position
        logic pg_rd;     // generator: advance i, read S[i]
        logic pg_sw;     // generator: advance j, read S[j]
        logic pg_wa;     // generator: write S[i], read S[t]
        logic pg_out;    // generator: write S[j]
        logic pg_load;   // generator: load the result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic n_last;    // step counter at its final value
        logic key_ok;    // key index inside the key store
        logic out_free;  // result register can take a new byte
    } t_status;

    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

/* hw/rtl/rc4_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 generic RAM
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rc4_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents when the same entry is written
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/rc4_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 controller
// Sequences key writes, the key schedule and one generator step per byte.
// ----------------------------------------------------------------------------
module rc4_ctrl
    import rc4_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_action,
    input  logic    i_restart,
    input  t_status i_status,
    output logic    o_stall,
    output t_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_KS_RD = 4'd2;
    localparam logic [3:0] S_KS_SW = 4'd3;
    localparam logic [3:0] S_KS_WA = 4'd4;
    localparam logic [3:0] S_KS_WB = 4'd5;
    localparam logic [3:0] S_PG_RD = 4'd6;
    localparam logic [3:0] S_PG_SW = 4'd7;
    localparam logic [3:0] S_PG_WA = 4'd8;
    localparam logic [3:0] S_PG_OUT = 4'd9;

    logic [3:0] r_state, n_state;
    logic       r_sched_ok, n_sched_ok;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_sched_ok = r_sched_ok;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_action == ACT_KEY) begin
                        o_cmd.key_wr = 1'b1;
                        if (i_status.key_ok) begin
                            n_sched_ok = 1'b0;
                        end
                    end else begin
                        o_cmd.latch = 1'b1;
                        if (i_restart || !r_sched_ok) begin
                            o_cmd.ks_start = 1'b1;
                            n_state        = S_INIT;
                        end else begin
                            n_state = S_PG_RD;
                        end
                    end
                end
            end
            S_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (i_status.n_last) begin
                    n_state = S_KS_RD;
                end
            end
            S_KS_RD: begin
                o_cmd.ks_rd = 1'b1;
                n_state     = S_KS_SW;
            end
            S_KS_SW: begin
                o_cmd.ks_sw = 1'b1;
                n_state     = S_KS_WA;
            end
            S_KS_WA: begin
                o_cmd.ks_wa = 1'b1;
                n_state     = S_KS_WB;
            end
            S_KS_WB: begin
                o_cmd.ks_wb = 1'b1;
                if (i_status.n_last) begin
                    n_sched_ok = 1'b1;
                    n_state    = S_PG_RD;
                end else begin
                    n_state = S_KS_RD;
                end
            end
            S_PG_RD: begin
                o_cmd.pg_rd = 1'b1;
                n_state     = S_PG_SW;
            end
            S_PG_SW: begin
                o_cmd.pg_sw = 1'b1;
                n_state     = S_PG_WA;
            end
            S_PG_WA: begin
                o_cmd.pg_wa = 1'b1;
                n_state     = S_PG_OUT;
            end
            S_PG_OUT: begin
                o_cmd.pg_out = 1'b1;
                // hold until the result register is free
                if (i_status.out_free) begin
                    o_cmd.pg_load = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_sched_ok <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_sched_ok <= n_sched_ok;
        end
    end

endmodule

/* hw/rtl/rc4_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 datapath
// S-box and key store memories, indices, key length and result register.
// ----------------------------------------------------------------------------
module rc4_dp
    import rc4_pkg::*;
#(
    parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic [BYTE_W-1:0]    i_key_index,
    input  logic [BYTE_W-1:0]    i_value,
    input  logic                 i_cfg_wr_en,
    input  logic [KEY_LEN_W-1:0] i_cfg_wr_data,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic [BYTE_W-1:0]    o_out_byte
);

    localparam int                   KEY_AW  = addr_w(MAX_KEY_BYTES);
    localparam int                   SBOX_AW = addr_w(SBOX_DEPTH);
    localparam logic [KEY_LEN_W-1:0] MAX_LEN = KEY_LEN_W'(MAX_KEY_BYTES);

    logic [KEY_LEN_W-1:0] r_key_len;
    logic [BYTE_W-1:0]    r_value;
    logic [SBOX_AW-1:0]   r_n;
    logic [KEY_AW-1:0]    r_kpos;
    logic [BYTE_W-1:0]    r_kj;
    logic [BYTE_W-1:0]    r_i;
    logic [BYTE_W-1:0]    r_j;
    logic [BYTE_W-1:0]    r_si;
    logic [BYTE_W-1:0]    r_sj;
    logic [BYTE_W-1:0]    r_t;
    logic [BYTE_W-1:0]    r_out_byte;
    logic                 r_out_valid;

    logic [BYTE_W-1:0]    w_s_rdata;
    logic [BYTE_W-1:0]    w_k_rdata;
    logic                 w_s_we;
    logic [SBOX_AW-1:0]   w_s_waddr;
    logic [BYTE_W-1:0]    w_s_wdata;
    logic [SBOX_AW-1:0]   w_s_raddr;
    logic [BYTE_W-1:0]    w_kj_next;
    logic [BYTE_W-1:0]    w_i_next;
    logic [BYTE_W-1:0]    w_j_next;
    logic [BYTE_W-1:0]    w_t;
    logic [BYTE_W-1:0]    w_ks;
    logic [KEY_LEN_W-1:0] w_eff_len;
    logic [KEY_LEN_W-1:0] w_kpos_inc;
    logic                 w_key_ok;
    logic                 w_out_free;

    assign w_key_ok   = ({1'b0, i_key_index} < MAX_LEN);
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_kj_next  = r_kj + w_s_rdata + w_k_rdata;
    assign w_i_next   = r_i + 8'd1;
    assign w_j_next   = r_j + w_s_rdata;
    assign w_t        = r_si + w_s_rdata;
    assign w_kpos_inc = {{(KEY_LEN_W - KEY_AW){1'b0}}, r_kpos} + 9'd1;

    assign o_status.n_last   = (r_n == '1);
    assign o_status.key_ok   = w_key_ok;
    assign o_status.out_free = w_out_free;

    // clamp the key length into 1 .. MAX_KEY_BYTES
    always_comb begin
        priority if (r_key_len == '0) begin
            w_eff_len = 9'd1;
        end else if (r_key_len > MAX_LEN) begin
            w_eff_len = MAX_LEN;
        end else begin
            w_eff_len = r_key_len;
        end
    end

    // keystream byte: forward entries swapped since the read was issued
    always_comb begin
        priority if (r_t == r_j) begin
            w_ks = r_si;
        end else if (r_t == r_i) begin
            w_ks = r_sj;
        end else begin
            w_ks = w_s_rdata;
        end
    end

    // S-box port selection
    always_comb begin
        w_s_we    = 1'b1;
        w_s_waddr = r_j;
        w_s_wdata = r_si;
        unique if (i_cmd.init_wr) begin
            w_s_waddr = r_n;
            w_s_wdata = r_n;
        end else if (i_cmd.ks_wa) begin
            w_s_waddr = r_n;
            w_s_wdata = w_s_rdata;
        end else if (i_cmd.ks_wb) begin
            w_s_waddr = r_kj;
            w_s_wdata = r_si;
        end else if (i_cmd.pg_wa) begin
            w_s_waddr = r_i;
            w_s_wdata = w_s_rdata;
        end else if (i_cmd.pg_out) begin
            w_s_waddr = r_j;
            w_s_wdata = r_si;
        end else begin
            w_s_we = 1'b0;
        end
    end

    always_comb begin
        unique if (i_cmd.ks_rd) begin
            w_s_raddr = r_n;
        end else if (i_cmd.ks_sw) begin
            w_s_raddr = w_kj_next;
        end else if (i_cmd.pg_rd) begin
            w_s_raddr = w_i_next;
        end else if (i_cmd.pg_sw) begin
            w_s_raddr = w_j_next;
        end else if (i_cmd.pg_wa) begin
            w_s_raddr = w_t;
        end else begin
            w_s_raddr = r_t;
        end
    end

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SBOX_DEPTH)
    ) u_sbox (
        .i_clk   (i_clk),
        .i_we    (w_s_we),
        .i_waddr (w_s_waddr),
        .i_wdata (w_s_wdata),
        .i_raddr (w_s_raddr),
        .o_rdata (w_s_rdata)
    );

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_KEY_BYTES)
    ) u_key (
        .i_clk   (i_clk),
        .i_we    (i_cmd.key_wr && w_key_ok),
        .i_waddr (i_key_index[KEY_AW-1:0]),
        .i_wdata (i_value),
        .i_raddr (r_kpos),
        .o_rdata (w_k_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len   <= KEY_LEN_RESET;
            r_out_valid <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_key_len <= i_cfg_wr_data;
            end
            if (i_cmd.pg_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.ks_start) begin
                r_i <= '0;
                r_j <= '0;
            end else if (i_cmd.pg_rd) begin
                r_i <= w_i_next;
            end else if (i_cmd.pg_sw) begin
                r_j <= w_j_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_value <= i_value;
        end
        if (i_cmd.ks_start) begin
            r_n    <= '0;
            r_kpos <= '0;
            r_kj   <= '0;
        end else if (i_cmd.init_wr) begin
            r_n <= r_n + 1'b1;
        end else if (i_cmd.ks_wb) begin
            r_n <= r_n + 1'b1;
            if (w_kpos_inc >= w_eff_len) begin
                r_kpos <= '0;
            end else begin
                r_kpos <= w_kpos_inc[KEY_AW-1:0];
            end
        end
        if (i_cmd.ks_sw) begin
            r_si <= w_s_rdata;
            r_kj <= w_kj_next;
        end else if (i_cmd.pg_sw) begin
            r_si <= w_s_rdata;
        end
        if (i_cmd.pg_wa) begin
            r_sj <= w_s_rdata;
            r_t  <= w_t;
        end
        if (i_cmd.pg_load) begin
            r_out_byte <= r_value ^ w_ks;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;

endmodule

/* hw/rtl/rc4_stream_cipher_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 stream cipher core
// Byte-wide RC4 cipher with a writable key store and on-demand key schedule.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  --------  ---------  -------------------  -----------------------------------
//  input     in         i_valid / o_stall    i_action, i_key_index, i_value,
//                                            i_restart
//  result    out        o_valid / i_stall    o_out_byte
//  config    in         i_cfg_wr_en          i_cfg_wr_data (key length)
//
//  A key write gives no result. A data byte takes the transfer, then four
//  S-box accesses through the single read and single write port of the
//  S-box RAM. A data byte that needs a key schedule first runs the identity
//  fill of the whole S-box and then the swap loop over every entry.
//  Reset clears the controller, the indices and the result valid and sets
//  the key length to one; the S-box and key store are left as they are and
//  the first data byte always runs the schedule.
//  A finished byte waits in the result register; the next item is taken
//  meanwhile, and a stall only holds the core once a second byte is ready.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_core
    import rc4_pkg::*;
#(
    parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input items
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_action,
    input  logic [BYTE_W-1:0]    i_key_index,
    input  logic [BYTE_W-1:0]    i_value,
    input  logic                 i_restart,
    // results
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [BYTE_W-1:0]    o_out_byte,
    // key length register
    input  logic                 i_cfg_wr_en,
    input  logic [KEY_LEN_W-1:0] i_cfg_wr_data
);

    t_cmd    w_cmd;
    t_status w_status;

    // sequencing: key writes, schedule fill and swap loop, generator step
    rc4_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_action  (i_action),
        .i_restart (i_restart),
        .i_status  (w_status),
        .o_stall   (o_stall),
        .o_cmd     (w_cmd)
    );

    // memories, indices and the result register
    rc4_dp #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_key_index   (i_key_index),
        .i_value       (i_value),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_out_byte    (o_out_byte)
    );

endmodule
